/* hdl/bilinear_downscaler_rgba_unit_assert.svh */
// ----------------------------------------------------------------------------
// bilinear downscaler assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BILINEAR_DOWNSCALER_RGBA_UNIT_ASSERT_SVH
`define BILINEAR_DOWNSCALER_RGBA_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bds check failed");

// next-cycle implication
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bds check failed");

`endif

/* hdl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// shared types, constants and blend helper of the bilinear downscaler
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int unsigned NUM_LANES = 4;
    localparam logic [17:0] STEP_MIN  = 18'h10000;
    localparam logic [17:0] STEP_MAX  = 18'h20000;

    typedef logic [31:0] pixel_t;

    // register indexes
    localparam logic [1:0] REG_TARGET_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TARGET_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE_STEP    = 2'd2;

    // lane job handed from control to the blend lanes
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       edge_row;
        logic       use_self;
        logic [7:0] wx;
        logic [7:0] wy;
        logic [10:0] x;
        logic [10:0] y;
    } lane_job_t;

    // one channel of (a*(256-w) + b*w) >> 8
    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] w);
        logic [16:0] acc;
        acc = 17'(a) * (17'd256 - 17'(w)) + 17'(b) * 17'(w);
        return acc[15:8];
    endfunction

endpackage

/* hdl/bds_lane.sv */
// ----------------------------------------------------------------------------
// bds_lane
// one channel: vertical blend, register, horizontal blend
// ----------------------------------------------------------------------------
module bds_lane
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] up,
    input  logic [7:0] cur,
    input  logic [7:0] up_left,
    input  logic [7:0] left,
    input  bds_pkg::lane_job_t job,
    output logic [7:0] result
);

    logic [7:0] vr_reg, vl_reg;
    logic [7:0] vr_next, vl_next;

    // bottom edge rows take the current row directly
    always_comb
    begin
        if (job.edge_row)
        begin
            vr_next = cur;
            vl_next = job.use_self ? cur : left;
        end
        else
        begin
            vr_next = bds_pkg::mix8(up, cur, job.wy);
            vl_next = job.use_self ? vr_next : bds_pkg::mix8(up_left, left, job.wy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vr_reg <= vr_next;
            vl_reg <= vl_next;
        end
    end

    logic [7:0] wx_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            wx_reg <= job.wx;
    end

    assign result = bds_pkg::mix8(vl_reg, vr_reg, wx_reg);

endmodule

/* hdl/bds_merge.sv */
// ----------------------------------------------------------------------------
// bds_merge
// joins the four channel lanes into one output word with its tags
// ----------------------------------------------------------------------------
module bds_merge
(
    input  logic [7:0] ch0,
    input  logic [7:0] ch1,
    input  logic [7:0] ch2,
    input  logic [7:0] ch3,
    input  logic [10:0] x,
    input  logic [10:0] y,
    output logic [55:0] word
);
    assign word = {2'b00, y, x, ch3, ch2, ch1, ch0};
endmodule

/* hdl/bilinear_downscaler_rgba_unit.sv */
// ----------------------------------------------------------------------------
// bilinear_downscaler_rgba_unit
// streaming bilinear rgba downscaler, factors 0.5 to 1.0
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order on s_axis, one word each; scaled
// pixels leave on m_axis with their target column and row. A source word
// yields zero to four results (up to two on the blended row and two on the
// bottom edge row). Words are taken one at a time. After acceptance the
// line store is read, and each evaluation cycle tries the next job. A job is
// captured by the four channel lanes (vertical blend registered, then
// horizontal blend) and then moves into a holding register. The held word
// goes to the output register once that is free, so that tlast can be set on
// the final one. The next source word is taken only once every result has
// reached the output register, so a wait on m_axis_tready can delay it. The
// previous source row sits in a line memory of MAX_SOURCE_WIDTH words with a
// registered read; no clearing pass is needed. Geometry registers are taken
// as written and clamped internally.
module bilinear_downscaler_rgba_unit
#(
    parameter int MAX_TARGET_DIM   = 2048,
    parameter int MAX_SOURCE_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    // source stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_ch0, in_ch1, in_ch2, in_ch3
    input  logic        s_axis_tuser,   // frame_start
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_ch0..3, out_x, out_y, zero pad
    output logic        m_axis_tlast    // last result of this source word
);

    localparam int CW = $clog2(MAX_SOURCE_WIDTH);
    localparam int TW = $clog2(MAX_TARGET_DIM + 1);
    localparam int WW = CW + 1;

    // ---------------- configuration ----------------
    logic [11:0] tw_cfg_reg, th_cfg_reg;
    logic [17:0] step_cfg_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_cfg_reg   <= 12'd1;
            th_cfg_reg   <= 12'd1;
            step_cfg_reg <= bds_pkg::STEP_MIN;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bds_pkg::REG_TARGET_WIDTH:  tw_cfg_reg   <= cfg_data[11:0];
                bds_pkg::REG_TARGET_HEIGHT: th_cfg_reg   <= cfg_data[11:0];
                bds_pkg::REG_SCALE_STEP:    step_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [TW-1:0] tw, th;
    logic [17:0]   s;
    logic [31:0]   srcw_raw, srch_raw;
    logic [WW-1:0] srcw;
    logic [TW:0]   srch;

    always_comb
    begin
        tw = (tw_cfg_reg == 12'd0) ? TW'(1)
           : (32'(tw_cfg_reg) > 32'(MAX_TARGET_DIM)) ? TW'(MAX_TARGET_DIM) : TW'(tw_cfg_reg);
        th = (th_cfg_reg == 12'd0) ? TW'(1)
           : (32'(th_cfg_reg) > 32'(MAX_TARGET_DIM)) ? TW'(MAX_TARGET_DIM) : TW'(th_cfg_reg);
        s  = (step_cfg_reg < bds_pkg::STEP_MIN) ? bds_pkg::STEP_MIN
           : (step_cfg_reg > bds_pkg::STEP_MAX) ? bds_pkg::STEP_MAX : step_cfg_reg;
    end

    // geometry products registered; user alters cfg only in idle, unchecked
    logic [WW-1:0] srcw_reg;
    logic [TW:0]   srch_reg;
    always_comb
    begin
        srcw_raw = (32'(tw) * 32'(s)) >> 16;
        srch_raw = (32'(th) * 32'(s)) >> 16;
        srcw = (srcw_raw == 32'd0) ? WW'(1)
             : (srcw_raw > 32'(MAX_SOURCE_WIDTH)) ? WW'(MAX_SOURCE_WIDTH) : WW'(srcw_raw);
        srch = (TW+1)'(srch_raw);
    end

    always_ff @(posedge clk)
    begin
        srcw_reg <= srcw;
        srch_reg <= srch;
    end

    // ---------------- state ----------------
    typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EVAL, ST_BLEND, ST_OUT, ST_DONE} state_t;
    state_t state_reg;

    logic [31:0]   pix_reg, up_reg, left_reg, upleft_reg;
    logic [WW-1:0] col_reg;
    logic [TW:0]   row_reg;
    logic [TW:0]   prow_reg;
    logic [TW:0]   ncb_reg, nce_reg;
    logic          phase_reg;      // 0 blended row, 1 edge row
    logic [1:0]    cnt_reg;        // results of this phase
    logic          nact_reg;
    bds_pkg::lane_job_t job_reg;

    // line memory
    logic [31:0] line_mem [MAX_SOURCE_WIDTH];
    logic [31:0] line_rd;
    logic [CW-1:0] rd_addr;
    assign rd_addr = s_axis_tuser ? '0 : col_reg[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            line_rd <= line_mem[rd_addr];
        if (state_reg == ST_DONE)
            line_mem[col_reg[CW-1:0]] <= pix_reg;
    end

    // candidate job evaluation for the current phase
    logic [TW:0]   y_cur, xcand;
    logic [31:0]   ys, nx;
    logic [WW-1:0] lx, hx;
    logic          row_ok, col_ok, job_ok;

    always_comb
    begin
        y_cur = prow_reg + ((phase_reg && nact_reg) ? (TW+1)'(1) : '0);
        ys    = 32'(y_cur) * 32'(s);
        xcand = phase_reg ? nce_reg : ncb_reg;
        nx    = 32'(xcand) * 32'(s);
        lx    = WW'(nx >> 16);
        hx    = (lx + WW'(1) < srcw_reg) ? lx + WW'(1) : lx;
        if (!phase_reg)
            row_ok = (row_reg >= (TW+1)'(1)) && (row_reg < srch_reg)
                     && (32'(y_cur) < 32'(th))
                     && ((ys >> 16) + 32'd1 == 32'(row_reg));
        else
            row_ok = (32'(row_reg) + 32'd1 == 32'(srch_reg))
                     && (32'(y_cur) < 32'(th)) && ((ys >> 16) == 32'(row_reg));
        col_ok = (32'(xcand) < 32'(tw)) && (hx == col_reg) && (cnt_reg != 2'd2);
        job_ok = row_ok && col_ok;
    end

    // lanes
    logic [7:0] lane_res [bds_pkg::NUM_LANES];
    logic       lane_en;
    assign lane_en = (state_reg == ST_BLEND);

    for (genvar g = 0; g < bds_pkg::NUM_LANES; g++)
    begin : g_lane
        bds_lane u_lane
        (
            .clk     (clk),
            .en      (lane_en),
            .up      (up_reg[8*g +: 8]),
            .cur     (pix_reg[8*g +: 8]),
            .up_left (upleft_reg[8*g +: 8]),
            .left    (left_reg[8*g +: 8]),
            .job     (job_reg),
            .result  (lane_res[g])
        );
    end

    logic [55:0] merged;
    bds_merge u_merge
    (
        .ch0  (lane_res[0]),
        .ch1  (lane_res[1]),
        .ch2  (lane_res[2]),
        .ch3  (lane_res[3]),
        .x    (job_reg.x),
        .y    (job_reg.y),
        .word (merged)
    );

    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        out_last_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // the result in the lanes is held until the next job is known, so that
    // tlast can be set on the final one
    logic held_reg;
    logic [55:0] held_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            prow_reg      <= '0;
            ncb_reg       <= '0;
            nce_reg       <= '0;
            left_reg      <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            held_reg      <= 1'b0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            nact_reg      <= 1'b0;
            job_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        pix_reg <= s_axis_tdata;
                        if (s_axis_tuser)
                        begin
                            col_reg  <= '0;
                            row_reg  <= '0;
                            prow_reg <= '0;
                            ncb_reg  <= '0;
                            nce_reg  <= '0;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    up_reg    <= line_rd;
                    phase_reg <= 1'b0;
                    cnt_reg   <= '0;
                    nact_reg  <= 1'b0;
                    held_reg  <= 1'b0;
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    // issue the next job for the lanes, or move on
                    if (job_ok)
                    begin
                        job_reg.valid    <= 1'b1;
                        job_reg.edge_row <= phase_reg;
                        job_reg.use_self <= (lx == col_reg);
                        job_reg.wx       <= nx[15:8];
                        job_reg.wy       <= ys[15:8];
                        job_reg.x        <= xcand[10:0];
                        job_reg.y        <= y_cur[10:0];
                        if (phase_reg) nce_reg <= xcand + (TW+1)'(1);
                        else           ncb_reg <= xcand + (TW+1)'(1);
                        cnt_reg   <= cnt_reg + 2'd1;
                        if (!phase_reg) nact_reg <= 1'b1;
                        state_reg <= ST_BLEND;
                    end
                    else if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                        cnt_reg   <= '0;
                        nact_reg  <= nact_reg || row_ok;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_BLEND:
                begin
                    // lanes capture the job at the edge leaving this state
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (held_reg && !out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= held_data_reg;
                        out_last_reg  <= !job_reg.valid;
                        held_reg      <= 1'b0;
                    end
                    else if (!held_reg)
                    begin
                        if (job_reg.valid)
                        begin
                            held_data_reg <= merged;
                            held_reg      <= 1'b1;
                            job_reg.valid <= 1'b0;
                            state_reg     <= ST_EVAL;
                        end
                        else
                            state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    upleft_reg <= up_reg;
                    left_reg   <= pix_reg;
                    if (col_reg + WW'(1) >= srcw_reg)
                    begin
                        col_reg <= '0;
                        ncb_reg <= '0;
                        nce_reg <= '0;
                        if (row_reg + (TW+1)'(1) >= srch_reg)
                        begin
                            row_reg  <= '0;
                            prow_reg <= '0;
                        end
                        else
                        begin
                            // the edge row only occurs on the last source row
                            row_reg  <= row_reg + (TW+1)'(1);
                            prow_reg <= prow_reg + (TW+1)'(nact_reg);
                        end
                    end
                    else
                        col_reg <= col_reg + WW'(1);
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hdl/bds_checker.sv */
// ----------------------------------------------------------------------------
// bds_checker
// port-level checks of the downscaler, bound to the top level
// ----------------------------------------------------------------------------
`include "bilinear_downscaler_rgba_unit_assert.svh"

module bds_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // a stalled result word holds
    `BDS_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // a stalled result word keeps its last flag
    `BDS_ASSERT_NEXT(a_last_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast))
    // padding stays zero
    `BDS_ASSERT_IMPL(a_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[55:54] == 2'b00)
    // a source word is never taken twice in a row
    `BDS_ASSERT_NEXT(a_gap, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind bilinear_downscaler_rgba_unit bds_checker u_bds_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
